### sv/fit_strategy_pool_allocator_unit_macros.svh
// Assertion shorthands shared by the allocator modules.
`ifndef FIT_STRATEGY_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_STRATEGY_POOL_ALLOCATOR_UNIT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define FSPA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define FSPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define FSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fspa_pkg.sv
`default_nettype none

package fspa_pkg;

    typedef logic [16:0] t_size;
    typedef logic [15:0] t_ofs;
    typedef logic [4:0]  t_live;
    typedef logic [1:0]  t_status;
    typedef logic [1:0]  t_fit;

    localparam int SIZE_W = 17;
    localparam int OFS_W  = 16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOSPACE = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_BADFREE = 2'd3;

    localparam t_fit FIT_FIRST = 2'd0;
    localparam t_fit FIT_BEST  = 2'd1;
    localparam t_fit FIT_WORST = 2'd2;

    localparam logic REG_FIT_STRATEGY = 1'b0;
    localparam logic REG_POOL_SIZE    = 1'b1;

    localparam t_fit  FIT_RESET  = FIT_FIRST;
    localparam t_size POOL_RESET = 17'h10000;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic    start;   // latch a new request
        logic    step;    // evaluate one gap of the scan
        logic    last;    // this gap runs to the pool end
        logic    move;    // copy the read entry to the write address
        logic    place;   // write the new entry at the write address
        logic    inc;
        logic    dec;
        logic    load;    // load the result register
        t_status status;
    } t_dp_ctl;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic is_free;
        logic want_zero;
        logic found;
        logic match;
        logic ofs_oob;
    } t_dp_stat;

endpackage

`default_nettype wire

### sv/fspa_dpath.sv
`default_nettype none

module fspa_dpath #(
    parameter int MAX_ENTRIES = 16,
    parameter int OFFSET_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire fspa_pkg::t_size         i_cfg_data,
    input  wire                          i_in_cmd,
    input  wire fspa_pkg::t_size         i_in_size,
    input  wire fspa_pkg::t_ofs          i_in_ofs,
    input  wire fspa_pkg::t_dp_ctl       i_ctl,
    input  wire [$clog2(MAX_ENTRIES)-1:0]   i_rd_addr,
    input  wire [$clog2(MAX_ENTRIES)-1:0]   i_wr_addr,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0] i_idx,
    output fspa_pkg::t_dp_stat           o_stat,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] o_count,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] o_best_idx,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] o_match_idx,
    output fspa_pkg::t_status            o_res_status,
    output fspa_pkg::t_ofs               o_res_offset,
    output fspa_pkg::t_live              o_res_count
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = OFFSET_BITS;
    localparam int EW = SW + fspa_pkg::SIZE_W;
    localparam int AW = ((OFFSET_BITS > fspa_pkg::SIZE_W) ? OFFSET_BITS : fspa_pkg::SIZE_W) + 1;
    localparam logic [AW-1:0] POOL_LIMIT = AW'(1) << OFFSET_BITS;
    localparam logic [AW-1:0] OFS_MASK   = POOL_LIMIT - AW'(1);

    // Allocation table: start offset in the upper bits, length in the lower.
    logic [EW-1:0]   r_tbl [MAX_ENTRIES];
    logic [EW-1:0]   r_rd_data;

    fspa_pkg::t_fit  r_fit;
    fspa_pkg::t_size r_pool;
    logic [CW-1:0]   r_count;

    logic            r_cmd;
    fspa_pkg::t_size r_want;
    logic [AW-1:0]   r_ofs;
    logic [AW-1:0]   r_cursor;
    logic            r_found;
    logic [AW-1:0]   r_best_at;
    logic [AW-1:0]   r_best_len;
    logic [CW-1:0]   r_best_idx;
    logic            r_match;
    logic [CW-1:0]   r_match_idx;

    fspa_pkg::t_status r_res_status;
    fspa_pkg::t_ofs    r_res_offset;
    fspa_pkg::t_live   r_res_count;

    logic [AW-1:0] pool_top;
    logic [AW-1:0] rd_start;
    logic [AW-1:0] rd_len;
    logic [AW-1:0] limit;
    logic [AW-1:0] gap;
    logic          fits;
    logic          better;

    always_comb begin
        pool_top = (AW'(r_pool) > POOL_LIMIT) ? POOL_LIMIT : AW'(r_pool);
        rd_start = AW'(r_rd_data[EW-1:fspa_pkg::SIZE_W]);
        rd_len   = AW'(r_rd_data[fspa_pkg::SIZE_W-1:0]);
        limit    = i_ctl.last ? pool_top : rd_start;
        gap      = (limit > r_cursor) ? (limit - r_cursor) : '0;
        fits     = (gap >= AW'(r_want));
        unique case (r_fit)
            fspa_pkg::FIT_FIRST: better = !r_found;
            fspa_pkg::FIT_BEST:  better = !r_found || (gap < r_best_len);
            fspa_pkg::FIT_WORST: better = !r_found || (gap > r_best_len);
            default:             better = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit   <= fspa_pkg::FIT_RESET;
            r_pool  <= fspa_pkg::POOL_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fspa_pkg::REG_FIT_STRATEGY: r_fit  <= i_cfg_data[1:0];
                    fspa_pkg::REG_POOL_SIZE:    r_pool <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ctl.inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_ctl.dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_tbl[i_rd_addr];
        if (i_ctl.move) begin
            r_tbl[i_wr_addr] <= r_rd_data;
        end else if (i_ctl.place) begin
            r_tbl[i_wr_addr] <= {r_best_at[SW-1:0], r_want};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cmd    <= i_in_cmd;
            r_want   <= i_in_size;
            r_ofs    <= AW'(i_in_ofs) & OFS_MASK;
            r_cursor <= '0;
            r_found  <= 1'b0;
            r_match  <= 1'b0;
        end else if (i_ctl.step) begin
            if (fits && better) begin
                r_found    <= 1'b1;
                r_best_at  <= r_cursor;
                r_best_len <= gap;
                r_best_idx <= i_idx;
            end
            if (!i_ctl.last) begin
                r_cursor <= rd_start + rd_len;
                if (!r_match && (rd_start == r_ofs)) begin
                    r_match     <= 1'b1;
                    r_match_idx <= i_idx;
                end
            end
        end
        if (i_ctl.load) begin
            r_res_status <= i_ctl.status;
            r_res_offset <= ((i_ctl.status == fspa_pkg::ST_OK) && (r_cmd == fspa_pkg::CMD_ALLOC))
                            ? r_best_at[fspa_pkg::OFS_W-1:0] : '0;
            r_res_count  <= fspa_pkg::t_live'(r_count);
        end
    end

    assign o_stat.is_free   = (r_cmd == fspa_pkg::CMD_FREE);
    assign o_stat.want_zero = (r_want == '0);
    assign o_stat.found     = r_found;
    assign o_stat.match     = r_match;
    assign o_stat.ofs_oob   = (r_ofs >= pool_top);
    assign o_count          = r_count;
    assign o_best_idx       = r_best_idx;
    assign o_match_idx      = r_match_idx;
    assign o_res_status     = r_res_status;
    assign o_res_offset     = r_res_offset;
    assign o_res_count      = r_res_count;

endmodule

`default_nettype wire

### sv/fspa_ctrl.sv
`default_nettype none
`include "fit_strategy_pool_allocator_unit_macros.svh"

module fspa_ctrl #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    input  wire fspa_pkg::t_dp_stat          i_stat,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0]  i_count,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0]  i_best_idx,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0]  i_match_idx,
    output fspa_pkg::t_dp_ctl                o_ctl,
    output logic [$clog2(MAX_ENTRIES)-1:0]   o_rd_addr,
    output logic [$clog2(MAX_ENTRIES)-1:0]   o_wr_addr,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] o_idx
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_SHIFT_UP = 3'd3;
    localparam logic [2:0] S_SHIFT_DN = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    fspa_pkg::t_status r_status, n_status;
    logic              r_out_valid, n_out_valid;
    logic [CW-1:0]     rd_next;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_status = r_status;
        rd_next  = '0;
        o_ctl    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.start = 1'b1;
                    n_idx       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // Prefetch the next entry while this gap is evaluated.
                rd_next    = r_idx + CW'(1);
                o_ctl.step = 1'b1;
                o_ctl.last = (r_idx == i_count);
                if (r_idx == i_count) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_DECIDE: begin
                if (!i_stat.is_free) begin
                    if (i_stat.want_zero || !i_stat.found) begin
                        n_status = fspa_pkg::ST_NOSPACE;
                        n_state  = S_DONE;
                    end else if (i_count >= CW'(MAX_ENTRIES)) begin
                        n_status = fspa_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = i_count;
                        rd_next = i_count - CW'(1);
                        n_state = S_SHIFT_UP;
                    end
                end else begin
                    if (i_stat.ofs_oob || !i_stat.match) begin
                        n_status = fspa_pkg::ST_BADFREE;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = i_match_idx;
                        rd_next = i_match_idx + CW'(1);
                        n_state = S_SHIFT_DN;
                    end
                end
            end
            S_SHIFT_UP: begin
                // Entries move up one slot, highest first, until the gap slot opens.
                rd_next = r_idx - CW'(2);
                if (r_idx == i_best_idx) begin
                    o_ctl.place = 1'b1;
                    o_ctl.inc   = 1'b1;
                    n_status    = fspa_pkg::ST_OK;
                    n_state     = S_DONE;
                end else begin
                    o_ctl.move = 1'b1;
                    n_idx      = r_idx - CW'(1);
                end
            end
            S_SHIFT_DN: begin
                rd_next = r_idx + CW'(2);
                if ((r_idx + CW'(1)) == i_count) begin
                    o_ctl.dec = 1'b1;
                    n_status  = fspa_pkg::ST_OK;
                    n_state   = S_DONE;
                end else begin
                    o_ctl.move = 1'b1;
                    n_idx      = r_idx + CW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_ctl.status = r_status;
        n_out_valid  = o_ctl.load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_status    <= fspa_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rd_addr   = rd_next[IW-1:0];
    assign o_wr_addr   = r_idx[IW-1:0];
    assign o_idx       = r_idx;

    `FSPA_ASSERT_NEXT(a_accept_scans, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid, r_state == S_SCAN, "accepted request did not start a scan")
    `FSPA_ASSERT_IMP(a_up_range, i_clk, i_rst_n, r_state == S_SHIFT_UP, (r_idx <= i_count) && (r_idx >= i_best_idx), "insert shift left its range")
    `FSPA_ASSERT_IMP(a_dn_range, i_clk, i_rst_n, r_state == S_SHIFT_DN, r_idx < i_count, "remove shift left its range")
    `FSPA_ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, i_count <= CW'(MAX_ENTRIES), "live count beyond table depth")
    `FSPA_ASSERT_IMP(a_load_room, i_clk, i_rst_n, o_ctl.load, !r_out_valid || i_out_ready, "result overwrote a pending beat")

endmodule

`default_nettype wire

### sv/fit_strategy_pool_allocator_unit.sv
// Pool allocator with first, best and worst fit placement.
// Requests arrive on the s_axis channel: s_axis_tuser selects allocate (0) or
// free (1), s_axis_tdata carries the request size and the offset to free.
// Each request gives one result beat on m_axis: a status in m_axis_tuser and
// the block offset and live count in m_axis_tdata.
// The cfg channel writes the fit rule (index 0) and the pool size (index 1);
// it is always ready, and the user must write it only while no request is in
// flight; the block itself does not enforce this. A request scans the
// address-ordered table one entry per cycle (count + 1 gaps), then decides,
// then shifts the table one entry per cycle through one read and one write
// port, and loads the result register in the done state once the result
// output is free. Failed requests skip the shift.
// The next request is taken once the block is back in idle, even while the
// previous result beat still waits; if the receiver stalls longer, the block
// holds its finished result and stops taking requests.
// Reset clears the live count, sets first fit and a pool size of 0x10000; the
// table memory is not cleared, since only live entries are ever used.
`default_nettype none

module fit_strategy_pool_allocator_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int OFFSET_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,  // request_size[16:0], free_offset[32:17]
    input  wire [0:0]   s_axis_tuser,  // command[0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,  // block_offset[15:0], live_count[20:16]
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire [16:0]  i_cfg_data
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    fspa_pkg::t_dp_ctl  ctl;
    fspa_pkg::t_dp_stat stat;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      wr_addr;
    logic [CW-1:0]      idx;
    logic [CW-1:0]      count;
    logic [CW-1:0]      best_idx;
    logic [CW-1:0]      match_idx;
    fspa_pkg::t_status  res_status;
    fspa_pkg::t_ofs     res_offset;
    fspa_pkg::t_live    res_count;

    assign o_cfg_ready = 1'b1;

    fspa_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .i_count     (count),
        .i_best_idx  (best_idx),
        .i_match_idx (match_idx),
        .o_ctl       (ctl),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_idx       (idx)
    );

    fspa_dpath #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_cmd     (s_axis_tuser[0]),
        .i_in_size    (s_axis_tdata[16:0]),
        .i_in_ofs     (s_axis_tdata[32:17]),
        .i_ctl        (ctl),
        .i_rd_addr    (rd_addr),
        .i_wr_addr    (wr_addr),
        .i_idx        (idx),
        .o_stat       (stat),
        .o_count      (count),
        .o_best_idx   (best_idx),
        .o_match_idx  (match_idx),
        .o_res_status (res_status),
        .o_res_offset (res_offset),
        .o_res_count  (res_count)
    );

    assign m_axis_tdata = {3'b000, res_count, res_offset};
    assign m_axis_tuser = res_status;

endmodule

`default_nettype wire
